[rtl/core/trf_pkg.sv]
// ----------------------------------------------------------------------------
// trf_pkg
// Shared types, widths and codes of the timestamp replay filter.
// ----------------------------------------------------------------------------
package trf_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int KEY_W       = 32;
   localparam int STAMP_W     = 64;
   localparam int TIME_W      = 48;
   localparam int MAXREC_W    = 7;
   localparam int MS_W        = 32;
   localparam int CMP_W       = (CNT_W > MAXREC_W) ? CNT_W : MAXREC_W;

   localparam int CSR_DATA_W  = 32;
   localparam int REG_NUM     = 3;
   localparam int CSR_IDX_W   = $clog2(REG_NUM);
   localparam int CSR_ADDR_W  = CSR_IDX_W + 2;

   localparam logic [MAXREC_W-1:0] MAX_RECORDS_RESET = MAXREC_W'(64);
   localparam logic [MS_W-1:0]     ONE_HOUR_MS       = MS_W'(3600000);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MAX_RECORDS = CSR_IDX_W'(0),
      REG_MAX_LIFETIME = CSR_IDX_W'(1),
      REG_GRACE_PERIOD = CSR_IDX_W'(2)
   } trf_reg_type;

   typedef enum logic {
      KIND_CHECK  = 1'b0,
      KIND_COMMIT = 1'b1
   } trf_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_TS     = 2'd1,
      STATUS_OUTSIDE   = 2'd2,
      STATUS_REORDERED = 2'd3
   } trf_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAN,
      ST_JUDGE,
      ST_CREMOVE,
      ST_CAPPEND,
      ST_DONE
   } trf_state_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [STAMP_W-1:0] stamp;
      logic [TIME_W-1:0]  refreshed;
   } trf_entry_type;

   typedef struct packed {
      logic pop;         // every cell takes its upper neighbour
      logic remove_hit;  // cells at and above the matching key shift down
      logic append;      // first free cell loads the item
   } trf_ctrl_type;

endpackage

[rtl/core/trf_if.sv]
// ----------------------------------------------------------------------------
// trf_req_if / trf_rsp_if
// Valid/ready channels carrying filter requests and responses.
// ----------------------------------------------------------------------------
interface trf_req_if;
   import trf_pkg::*;

   logic               valid;
   logic               ready;
   logic               kind;
   logic [KEY_W-1:0]   key_id;
   logic               has_timestamp;
   logic [STAMP_W-1:0] timestamp_ms;
   logic [TIME_W-1:0]  wall_time_ms;
   logic [TIME_W-1:0]  steady_time_ms;

   modport source (output valid, kind, key_id, has_timestamp, timestamp_ms,
                   wall_time_ms, steady_time_ms, input ready);
   modport sink   (input valid, kind, key_id, has_timestamp, timestamp_ms,
                   wall_time_ms, steady_time_ms, output ready);
endinterface

interface trf_rsp_if;
   logic       valid;
   logic       ready;
   logic       accepted;
   logic [1:0] status;

   modport source  (output valid, accepted, status, input ready);
   modport sink    (input valid, accepted, status, output ready);
endinterface

[rtl/core/trf_cell.sv]
// ----------------------------------------------------------------------------
// trf_cell
// One table slot: holds an entry, compares its key and shifts to its neighbour.
// ----------------------------------------------------------------------------
module trf_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  trf_pkg::trf_ctrl_type  ctrl,
   input  trf_pkg::trf_entry_type item,
   input  trf_pkg::trf_entry_type next_entry,
   input  logic                   next_valid,
   input  logic                   prev_valid,
   input  logic                   hit_in,
   output logic                   hit_out,
   output trf_pkg::trf_entry_type entry,
   output logic                   valid,
   output logic                   reorder
);
   import trf_pkg::*;

   trf_entry_type entry_ff, entry_in;
   logic          valid_ff, valid_in;
   logic          my_hit;

   assign my_hit  = valid_ff && (entry_ff.key == item.key);
   assign hit_out = hit_in || my_hit;
   // stored stamp not older than the request
   assign reorder = my_hit && (item.stamp <= entry_ff.stamp);

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      priority if (ctrl.pop || (ctrl.remove_hit && hit_out)) begin
         entry_in = next_entry;
         valid_in = next_valid;
      end else if (ctrl.append && !valid_ff && prev_valid) begin
         entry_in = item;
         valid_in = 1'b1;
      end else begin
         entry_in = entry_ff;
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule

[rtl/core/trf_row.sv]
// ----------------------------------------------------------------------------
// trf_row
// Age-ordered row of table cells, oldest entry in cell zero.
// ----------------------------------------------------------------------------
module trf_row (
   input  logic                   clock,
   input  logic                   reset,
   input  trf_pkg::trf_ctrl_type  ctrl,
   input  trf_pkg::trf_entry_type item,
   output trf_pkg::trf_entry_type head,
   output logic                   hit_any,
   output logic                   reorder_any
);
   import trf_pkg::*;

   trf_entry_type          entry_w [TABLE_DEPTH+1];
   logic [TABLE_DEPTH:0]   valid_w;
   logic [TABLE_DEPTH:0]   hit_w;
   logic [TABLE_DEPTH-1:0] prev_w;
   logic [TABLE_DEPTH-1:0] reorder_w;

   // nothing above the top cell
   assign entry_w[TABLE_DEPTH] = '0;
   assign valid_w[TABLE_DEPTH] = 1'b0;
   assign hit_w[0]             = 1'b0;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign prev_w[i] = 1'b1;
      end else begin : g_rest
         assign prev_w[i] = valid_w[i-1];
      end

      trf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .item       (item),
         .next_entry (entry_w[i+1]),
         .next_valid (valid_w[i+1]),
         .prev_valid (prev_w[i]),
         .hit_in     (hit_w[i]),
         .hit_out    (hit_w[i+1]),
         .entry      (entry_w[i]),
         .valid      (valid_w[i]),
         .reorder    (reorder_w[i])
      );
   end

   assign head        = entry_w[0];
   assign hit_any     = hit_w[TABLE_DEPTH];
   assign reorder_any = |reorder_w;

endmodule

[rtl/core/timestamp_replay_filter_core.sv]
// ----------------------------------------------------------------------------
// timestamp_replay_filter_core
// Per-key timestamp anti-replay table with APB configuration.
// ----------------------------------------------------------------------------
// Requests arrive on req_ch (valid/ready). A check request first drops
// entries from the old end of the table while the oldest is aged or the
// table holds more than max_records, and answers on rsp_ch with a status:
// ok, no timestamp, outside grace window or reordered. A commit request
// stores the key's timestamp as the newest entry, removing any entry of
// the same key, else evicting the oldest when the table is full, and
// always answers ok. A check passes through clean, judge and done; each
// entry dropped in cleanup shifts the whole row down one cell per cycle.
// A commit passes through remove, append and done. The next request is
// taken in the cycle after the answer is loaded into the output register.
// The key search is a parallel compare across the row of cells.
// One request is in flight at a time; the response sits in an output
// register, so a new request is taken while the previous response waits.
// When the receiver stalls, the response holds and the block stops after
// finishing its current request. Reset empties the table and loads the
// register defaults (max_records 64, lifetime and grace one hour).
// csr_* is an APB slave: max_records at 0x0, max_lifetime_ms at 0x4,
// grace_period_ms at 0x8; write it only while the block is idle.
// ----------------------------------------------------------------------------
module timestamp_replay_filter_core (
   input  logic                             clock,
   input  logic                             reset,
   trf_req_if.sink                          req_ch,
   trf_rsp_if.source                        rsp_ch,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [trf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [trf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [trf_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import trf_pkg::*;

   // configuration
   logic [MAXREC_W-1:0] max_records_ff;
   logic [MS_W-1:0]     max_lifetime_ff;
   logic [MS_W-1:0]     grace_period_ff;
   trf_reg_type         csr_idx;
   logic                csr_write;

   assign csr_idx    = trf_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_records_ff  <= MAX_RECORDS_RESET;
         max_lifetime_ff <= ONE_HOUR_MS;
         grace_period_ff <= ONE_HOUR_MS;
      end else if (csr_write) begin
         unique case (csr_idx)
            REG_MAX_RECORDS:  max_records_ff  <= csr_pwdata[MAXREC_W-1:0];
            REG_MAX_LIFETIME: max_lifetime_ff <= csr_pwdata[MS_W-1:0];
            REG_GRACE_PERIOD: grace_period_ff <= csr_pwdata[MS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_MAX_RECORDS:  csr_prdata = CSR_DATA_W'(max_records_ff);
         REG_MAX_LIFETIME: csr_prdata = CSR_DATA_W'(max_lifetime_ff);
         REG_GRACE_PERIOD: csr_prdata = CSR_DATA_W'(grace_period_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // request capture
   trf_state_type       state_ff, state_in;
   trf_entry_type       item_ff;
   logic                has_ts_ff;
   logic                grace_bad_ff;
   logic                req_xfer;
   logic                wall_ge_g;
   logic [TIME_W-1:0]   wall_low;
   logic [TIME_W:0]     wall_high;
   logic                grace_bad;

   assign req_xfer  = req_ch.valid && req_ch.ready;
   assign wall_ge_g = req_ch.wall_time_ms >= TIME_W'(grace_period_ff);
   assign wall_low  = req_ch.wall_time_ms - TIME_W'(grace_period_ff);
   assign wall_high = (TIME_W+1)'(req_ch.wall_time_ms) + (TIME_W+1)'(grace_period_ff);
   assign grace_bad = (wall_ge_g && (req_ch.timestamp_ms < STAMP_W'(wall_low)))
                   || (req_ch.timestamp_ms > STAMP_W'(wall_high));

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff.key       <= req_ch.key_id;
         item_ff.stamp     <= req_ch.timestamp_ms;
         item_ff.refreshed <= req_ch.steady_time_ms;
         has_ts_ff         <= req_ch.has_timestamp;
         grace_bad_ff      <= grace_bad;
      end
   end

   // table
   trf_ctrl_type        ctrl;
   trf_entry_type       head;
   logic                hit_any;
   logic                reorder_any;

   trf_row u_row (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .item        (item_ff),
      .head        (head),
      .hit_any     (hit_any),
      .reorder_any (reorder_any)
   );

   logic [CNT_W-1:0]    count_ff, count_in;
   logic                head_expired;
   logic                pop_need;
   logic                table_full;

   // no wrap: 49-bit sum against steady time
   assign head_expired = ((TIME_W+1)'(head.refreshed) + (TIME_W+1)'(max_lifetime_ff))
                         <= (TIME_W+1)'(item_ff.refreshed);
   assign pop_need     = (count_ff != '0)
                      && (head_expired || (CMP_W'(count_ff) > CMP_W'(max_records_ff)));
   assign table_full   = count_ff == CNT_W'(TABLE_DEPTH);

   always_comb begin
      count_in = count_ff;
      priority if (ctrl.pop || ctrl.remove_hit) begin
         count_in = count_ff - CNT_W'(1);
      end else if (ctrl.append) begin
         count_in = count_ff + CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = (trf_kind_type'(req_ch.kind) == KIND_COMMIT) ? ST_CREMOVE : ST_CLEAN;
            end
         end
         ST_CLEAN: begin
            if (!pop_need) begin
               state_in = ST_JUDGE;
            end
         end
         ST_JUDGE:   state_in = ST_DONE;
         ST_CREMOVE: state_in = ST_CAPPEND;
         ST_CAPPEND: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_ch.valid || rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   logic                status_load;
   logic                commit_load;
   logic                rsp_load;

   always_comb begin
      ctrl         = '0;
      req_ch.ready = 1'b0;
      status_load  = 1'b0;
      commit_load  = 1'b0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE:    req_ch.ready = 1'b1;
         ST_CLEAN:   ctrl.pop = pop_need;
         ST_JUDGE:   status_load = 1'b1;
         ST_CREMOVE: begin
            ctrl.remove_hit = hit_any;
            ctrl.pop        = !hit_any && table_full;
         end
         ST_CAPPEND: begin
            ctrl.append = 1'b1;
            commit_load = 1'b1;
         end
         ST_DONE:    rsp_load = !rsp_ch.valid || rsp_ch.ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // judgement and output register
   trf_status_type      status_ff;
   trf_status_type      rsp_status_ff;
   logic                rsp_valid_ff;

   always_ff @(posedge clock) begin
      priority if (status_load) begin
         priority if (!has_ts_ff) begin
            status_ff <= STATUS_NO_TS;
         end else if (grace_bad_ff) begin
            status_ff <= STATUS_OUTSIDE;
         end else if (reorder_any) begin
            status_ff <= STATUS_REORDERED;
         end else begin
            status_ff <= STATUS_OK;
         end
      end else if (commit_load) begin
         status_ff <= STATUS_OK;
      end else begin
         status_ff <= status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.status   = rsp_status_ff;
   assign rsp_ch.accepted = rsp_status_ff == STATUS_OK;

endmodule

[rtl/core/trf_checker.sv]
// ----------------------------------------------------------------------------
// trf_checker
// Port-level checks of the replay filter, bound to the top level.
// ----------------------------------------------------------------------------
module trf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_accepted,
   input logic [1:0] rsp_status
);
   import trf_pkg::*;

   // a stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // accepted flag agrees with the status code
   a_accept_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_accepted == (rsp_status == STATUS_OK)))
      else $error("accepted flag disagrees with status");

   // one request at a time: no transfer straight after a transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // reset clears the response channel
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind timestamp_replay_filter_core trf_checker u_trf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_accepted (rsp_ch.accepted),
   .rsp_status   (rsp_ch.status)
);
